>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the serial interface RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/acia_pkg.sv
// Types, codes and helper functions for the serial interface.
`timescale 1ns / 1ps
package acia_pkg;

  // Bus access / clock tick codes carried in tuser
  typedef enum logic [2:0] {
    KIND_CTRL_WR = 3'd0,
    KIND_DATA_WR = 3'd1,
    KIND_STAT_RD = 3'd2,
    KIND_DATA_RD = 3'd3,
    KIND_RX_CLK  = 3'd4,
    KIND_TX_CLK  = 3'd5
  } kind_t;

  // Character framing phases
  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_DATA     = 3'd1,
    PH_PARITY   = 3'd2,
    PH_STOP     = 3'd3,
    PH_COMPLETE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    PAR_NONE = 2'd0,
    PAR_EVEN = 2'd1,
    PAR_ODD  = 2'd2
  } par_t;

  // Control word divide codes
  localparam logic [1:0] DIV_1      = 2'd0;
  localparam logic [1:0] DIV_16     = 2'd1;
  localparam logic [1:0] DIV_64     = 2'd2;
  localparam logic [1:0] DIV_MRESET = 2'd3;

  localparam int unsigned CTRL_RIE_BIT = 7;
  localparam logic [3:0]  BITS_7      = 4'd7;
  localparam logic [3:0]  BITS_8      = 4'd8;
  localparam logic [5:0]  PRE_16_LIM  = 6'd16;

  // Receiver control from the top level
  typedef struct packed {
    logic       mreset;
    logic       start;
    logic       tick;
    logic       line;
    logic [2:0] fmt;
    logic [1:0] div_sel;
  } rx_cmd_t;

  // Receiver status events
  typedef struct packed {
    logic full_set;
    logic pe_set;
  } rx_evt_t;

  // Transmitter control from the top level
  typedef struct packed {
    logic       mreset;
    logic       load;
    logic       tick;
    logic [7:0] data;
    logic [2:0] fmt;
    logic [1:0] div_sel;
  } tx_cmd_t;

  typedef struct packed {
    logic tdre_set;
    logic line_nxt;
  } tx_stat_t;

  // 7-bit formats are codes 0..3
  function automatic logic fmt_is7(input logic [2:0] fmt);
    return ~fmt[2];
  endfunction

  function automatic logic [3:0] fmt_bits(input logic [2:0] fmt);
    return fmt[2] ? BITS_8 : BITS_7;
  endfunction

  function automatic par_t fmt_parity(input logic [2:0] fmt);
    par_t p;
    if (fmt inside {3'd0, 3'd2, 3'd6}) begin
      p = PAR_EVEN;
    end else if (fmt inside {3'd1, 3'd3, 3'd7}) begin
      p = PAR_ODD;
    end else begin
      p = PAR_NONE;
    end
    return p;
  endfunction

  // Prescaler step: returns {bit_time, next_count}
  function automatic logic [6:0] prescale_step(input logic [5:0] pre, input logic [1:0] sel);
    logic [5:0] nxt;
    logic       hit;
    nxt = pre + 6'd1;
    case (sel)
      DIV_16:  hit = (nxt >= PRE_16_LIM) || (nxt == 6'd0);
      DIV_64:  hit = (nxt == 6'd0);
      default: hit = 1'b1;
    endcase
    return hit ? {1'b1, 6'd0} : {1'b0, nxt};
  endfunction

endpackage

>>> hw/rtl/acia_rx.sv
// Receiver: prescaler, framing phases, shifter and holding register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acia_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  acia_pkg::rx_cmd_t cmd,
  output logic [7:0]        holding,
  output acia_pkg::rx_evt_t evt
);
  import acia_pkg::*;

  logic       run_r, run_nxt;
  logic [5:0] pre_r, pre_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       acc_r, acc_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic [6:0] ps;
  logic [7:0] sh_in;
  logic       acc_in;
  par_t       par;

  assign par     = fmt_parity(cmd.fmt);
  assign ps      = prescale_step(pre_r, cmd.div_sel);
  assign sh_in   = sh_r | {cmd.line, 7'd0};
  assign acc_in  = acc_r ^ cmd.line;
  assign holding = hold_r;

  // Next-state logic for one bus access or tick
  always_comb begin
    run_nxt   = run_r;
    pre_nxt   = pre_r;
    phase_nxt = phase_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    hold_nxt  = hold_r;
    evt       = '0;
    if (cmd.mreset) begin
      run_nxt   = 1'b0;
      pre_nxt   = '0;
      phase_nxt = PH_START;
      sh_nxt    = '0;
      cnt_nxt   = '0;
      acc_nxt   = 1'b0;
      hold_nxt  = '0;
    end else if (cmd.start) begin
      run_nxt = 1'b1;
      pre_nxt = '0;
    end else if (cmd.tick && run_r) begin
      pre_nxt = ps[5:0];
      if (ps[6]) begin
        case (phase_r)
          PH_DATA: begin
            acc_nxt = acc_in;
            if (cnt_r <= 4'd1) begin
              cnt_nxt   = '0;
              sh_nxt    = fmt_is7(cmd.fmt) ? (sh_in >> 1) : sh_in;
              phase_nxt = (par == PAR_NONE) ? PH_STOP : PH_PARITY;
            end else begin
              cnt_nxt = cnt_r - 4'd1;
              sh_nxt  = sh_in >> 1;
            end
          end
          PH_PARITY: begin
            evt.pe_set = (par == PAR_EVEN) ? acc_in : ~acc_in;
            acc_nxt    = 1'b0;
            phase_nxt  = PH_STOP;
          end
          PH_STOP: phase_nxt = PH_COMPLETE;
          PH_COMPLETE: begin
            hold_nxt     = sh_r;
            evt.full_set = 1'b1;
            phase_nxt    = PH_START;
          end
          default: begin
            // start bit hunt; stray phase codes land here too
            if (!cmd.line) begin
              sh_nxt    = '0;
              acc_nxt   = 1'b0;
              cnt_nxt   = fmt_bits(cmd.fmt);
              phase_nxt = PH_DATA;
            end else begin
              phase_nxt = PH_START;
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      pre_r   <= '0;
      phase_r <= PH_START;
      sh_r    <= '0;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
      hold_r  <= '0;
    end else begin
      run_r   <= run_nxt;
      pre_r   <= pre_nxt;
      phase_r <= phase_nxt;
      sh_r    <= sh_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      hold_r  <= hold_nxt;
    end
  end

  // A stopped receiver sits at start with a clear prescaler
  `ASSERT_IMPLY(a_rx_idle, !run_r, (phase_r == PH_START) && (pre_r == 6'd0), "rx stopped mid-frame")

endmodule

>>> hw/rtl/acia_tx.sv
// Transmitter: prescaler, framing phases, shifter and line driver.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acia_tx (
  input  logic               clk,
  input  logic               rst_n,
  input  acia_pkg::tx_cmd_t  cmd,
  output acia_pkg::tx_stat_t stat
);
  import acia_pkg::*;

  logic       run_r, run_nxt;
  logic [5:0] pre_r, pre_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       acc_r, acc_nxt;
  logic       line_r, line_nxt;
  logic [6:0] ps;
  par_t       par;

  assign par = fmt_parity(cmd.fmt);
  assign ps  = prescale_step(pre_r, cmd.div_sel);

  // Next-state logic for one bus access or tick
  always_comb begin
    run_nxt       = run_r;
    pre_nxt       = pre_r;
    phase_nxt     = phase_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    line_nxt      = line_r;
    stat.tdre_set = 1'b0;
    if (cmd.mreset) begin
      run_nxt   = 1'b0;
      pre_nxt   = '0;
      phase_nxt = PH_START;
      sh_nxt    = '0;
      cnt_nxt   = '0;
      acc_nxt   = 1'b0;
      line_nxt  = 1'b1;
    end else if (cmd.load) begin
      // phase kept: a load mid-character replaces the remaining bits
      sh_nxt  = cmd.data;
      run_nxt = 1'b1;
      pre_nxt = '0;
    end else if (cmd.tick && run_r) begin
      pre_nxt = ps[5:0];
      if (ps[6]) begin
        case (phase_r)
          PH_DATA: begin
            line_nxt = sh_r[0];
            acc_nxt  = acc_r ^ sh_r[0];
            sh_nxt   = sh_r >> 1;
            if (cnt_r <= 4'd1) begin
              cnt_nxt   = '0;
              phase_nxt = (par == PAR_NONE) ? PH_STOP : PH_PARITY;
            end else begin
              cnt_nxt = cnt_r - 4'd1;
            end
          end
          PH_PARITY: begin
            line_nxt  = (par == PAR_EVEN) ? acc_r : ~acc_r;
            acc_nxt   = 1'b0;
            phase_nxt = PH_STOP;
          end
          PH_STOP: begin
            line_nxt  = 1'b1;
            phase_nxt = PH_COMPLETE;
          end
          PH_COMPLETE: begin
            stat.tdre_set = 1'b1;
            run_nxt       = 1'b0;
            phase_nxt     = PH_START;
          end
          default: begin
            line_nxt  = 1'b0;
            acc_nxt   = 1'b0;
            cnt_nxt   = fmt_bits(cmd.fmt);
            phase_nxt = PH_DATA;
          end
        endcase
      end
    end
    stat.line_nxt = line_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      pre_r   <= '0;
      phase_r <= PH_START;
      sh_r    <= '0;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
      line_r  <= 1'b1;
    end else begin
      run_r   <= run_nxt;
      pre_r   <= pre_nxt;
      phase_r <= phase_nxt;
      sh_r    <= sh_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      line_r  <= line_nxt;
    end
  end

  // Idle transmitter holds the line high at start
  `ASSERT_IMPLY(a_tx_idle, !run_r, line_r && (phase_r == PH_START), "tx idle but line low")

endmodule

>>> hw/rtl/acia_serial_interface.sv
// Each word waits in the input register until the output register can take its result.
// Throughput: one word per cycle while out_tready is high; the input and output registers
// each hold one word, and every word is decoded and applied in a single pass between them.
// Reset (rst_n low, synchronous) empties both registers and restores idle status 0x02.
// A control write with divide code 3 is a master reset while the port stays live.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module acia_serial_interface (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] write_data, [8] rx_line, [15:9] zero
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [7:0] read_data, [8] tx_line, [9] irq_line, [15:10] zero
);
  import acia_pkg::*;

  // Input register
  logic       s1_vld_r;
  kind_t      s1_kind_r;
  logic [7:0] s1_wd_r;
  logic       s1_rx_r;
  logic       adv;

  // Output register
  logic        out_vld_r;
  logic [15:0] out_data_r;

  // Block state
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       mres_r, mres_nxt;
  logic [1:0] div_r, div_nxt;
  logic       st_rdrf_r, st_rdrf_nxt;
  logic       st_tdre_r, st_tdre_nxt;
  logic       st_pe_r, st_pe_nxt;
  logic       st_irq_r, st_irq_nxt;
  logic       irq_r, irq_nxt;

  rx_cmd_t    rx_cmd;
  rx_evt_t    rx_evt;
  tx_cmd_t    tx_cmd;
  tx_stat_t   tx_stat;
  logic [7:0] rx_hold;
  logic [7:0] rd;
  logic       ctrl_wr, mres_wr;

  assign adv        = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r || adv;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign ctrl_wr = adv && (s1_kind_r == KIND_CTRL_WR);
  assign mres_wr = ctrl_wr && (s1_wd_r[1:0] == DIV_MRESET);

  // Commands to the receiver and transmitter
  always_comb begin
    rx_cmd.mreset  = mres_wr;
    rx_cmd.start   = ctrl_wr && !mres_wr;
    rx_cmd.tick    = adv && (s1_kind_r == KIND_RX_CLK);
    rx_cmd.line    = s1_rx_r;
    rx_cmd.fmt     = ctrl_r[4:2];
    rx_cmd.div_sel = div_r;
    tx_cmd.mreset  = mres_wr;
    tx_cmd.load    = adv && (s1_kind_r == KIND_DATA_WR) && !mres_r;
    tx_cmd.tick    = adv && (s1_kind_r == KIND_TX_CLK);
    tx_cmd.data    = s1_wd_r;
    tx_cmd.fmt     = ctrl_r[4:2];
    tx_cmd.div_sel = div_r;
  end

  acia_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (rx_cmd),
    .holding (rx_hold),
    .evt     (rx_evt)
  );

  acia_tx u_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (tx_cmd),
    .stat  (tx_stat)
  );

  // Register decode, status update and read data
  always_comb begin
    ctrl_nxt    = ctrl_r;
    mres_nxt    = mres_r;
    div_nxt     = div_r;
    st_rdrf_nxt = st_rdrf_r;
    st_tdre_nxt = st_tdre_r;
    st_pe_nxt   = st_pe_r;
    st_irq_nxt  = st_irq_r;
    irq_nxt     = irq_r;
    rd          = '0;
    if (adv) begin
      case (s1_kind_r)
        KIND_CTRL_WR: begin
          ctrl_nxt = s1_wd_r;
          if (mres_wr) begin
            mres_nxt    = 1'b1;
            st_rdrf_nxt = 1'b0;
            st_tdre_nxt = 1'b1;
            st_pe_nxt   = 1'b0;
            st_irq_nxt  = 1'b0;
            irq_nxt     = 1'b0;
          end else begin
            mres_nxt = 1'b0;
            div_nxt  = s1_wd_r[1:0];
          end
        end
        KIND_DATA_WR: begin
          if (!mres_r) begin
            st_tdre_nxt = 1'b0;
          end
        end
        KIND_STAT_RD: rd = {st_irq_r, st_pe_r, 4'd0, st_tdre_r, st_rdrf_r};
        KIND_DATA_RD: begin
          st_rdrf_nxt = 1'b0;
          st_pe_nxt   = 1'b0;
          st_irq_nxt  = 1'b0;
          irq_nxt     = 1'b0;
          rd          = rx_hold;
        end
        KIND_RX_CLK: begin
          if (rx_evt.pe_set) begin
            st_pe_nxt = 1'b1;
          end
          if (rx_evt.full_set) begin
            st_rdrf_nxt = 1'b1;
            if (ctrl_r[CTRL_RIE_BIT]) begin
              st_irq_nxt = 1'b1;
              irq_nxt    = 1'b1;
            end
          end
        end
        KIND_TX_CLK: begin
          if (tx_stat.tdre_set) begin
            st_tdre_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= kind_t'(in_tuser);
      s1_wd_r   <= in_tdata[7:0];
      s1_rx_r   <= in_tdata[8];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {6'd0, irq_nxt, tx_stat.line_nxt, rd};
    end
  end

  // Control and status registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= '0;
      mres_r    <= 1'b0;
      div_r     <= DIV_1;
      st_rdrf_r <= 1'b0;
      st_tdre_r <= 1'b1;
      st_pe_r   <= 1'b0;
      st_irq_r  <= 1'b0;
      irq_r     <= 1'b0;
    end else begin
      ctrl_r    <= ctrl_nxt;
      mres_r    <= mres_nxt;
      div_r     <= div_nxt;
      st_rdrf_r <= st_rdrf_nxt;
      st_tdre_r <= st_tdre_nxt;
      st_pe_r   <= st_pe_nxt;
      st_irq_r  <= st_irq_nxt;
      irq_r     <= irq_nxt;
    end
  end

  // Interrupt pin tracks the interrupt status bit
  `ASSERT_ALWAYS(a_irq_match, irq_r == st_irq_r, "irq line and status bit differ")
  // Held in master reset: transmitter empty, nothing received
  `ASSERT_IMPLY(a_mres_idle, mres_r, st_tdre_r && !st_rdrf_r && !irq_r, "activity in master reset")
  // Master reset divide code is never latched as the divide
  `ASSERT_ALWAYS(a_div_legal, div_r != DIV_MRESET, "reset code latched as divide")

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking stream testbench for the serial interface: directed table, then random traffic.
module testbench;
  import acia_pkg::*;

  // Codes the package leaves unnamed; the block must treat them as no-ops
  localparam logic [2:0] KIND_SPARE_6 = 3'd6;
  localparam logic [2:0] KIND_SPARE_7 = 3'd7;

  // Status register bits
  localparam logic [7:0] STS_RX_FULL    = 8'h01;
  localparam logic [7:0] STS_TX_EMPTY   = 8'h02;
  localparam logic [7:0] STS_OVERRUN    = 8'h20;
  localparam logic [7:0] STS_PARITY_ERR = 8'h40;
  localparam logic [7:0] STS_IRQ        = 8'h80;

  localparam int DIRECTED_COUNT = 25;
  localparam int RANDOM_WORDS   = 800;
  localparam int CALM_TAIL      = 100;
  localparam int HOLD_AT        = 300;
  localparam int LONG_HOLD      = 80;
  localparam int PAUSE_AT       = 550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       tx;
    logic       irq;
  } acia_result_t;

  // One bus word; typed rows carry a hand-written result
  typedef struct packed {
    bit           typed;
    logic [2:0]   kind;
    logic [7:0]   wdata;
    logic         rx;
    acia_result_t want;
  } bus_word_t;

  // Directed table: reset values, spare codes, master reset, then a short live session
  localparam bus_word_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
    '{1'b1, KIND_STAT_RD, 8'h00, 1'b0, '{8'h02, 1'b1, 1'b0}},
    '{1'b1, KIND_DATA_RD, 8'h00, 1'b0, '{8'h00, 1'b1, 1'b0}},
    '{1'b1, KIND_RX_CLK,  8'h00, 1'b0, '{8'h00, 1'b1, 1'b0}},  // receiver not running
    '{1'b1, KIND_TX_CLK,  8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0}},  // transmitter not running
    '{1'b1, KIND_SPARE_6, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{1'b1, KIND_SPARE_7, 8'h00, 1'b0, '{8'h00, 1'b1, 1'b0}},
    '{1'b1, KIND_CTRL_WR, 8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0}},  // master reset, all bits set
    '{1'b1, KIND_DATA_WR, 8'hFF, 1'b0, '{8'h00, 1'b1, 1'b0}},  // dropped while in reset
    '{1'b1, KIND_STAT_RD, 8'h00, 1'b0, '{8'h02, 1'b1, 1'b0}},
    '{1'b1, KIND_CTRL_WR, 8'h94, 1'b0, '{8'h00, 1'b1, 1'b0}},  // div 1, 8N, rx irq on
    '{1'b1, KIND_DATA_WR, 8'h00, 1'b0, '{8'h00, 1'b1, 1'b0}},
    '{1'b1, KIND_STAT_RD, 8'h00, 1'b0, '{8'h00, 1'b1, 1'b0}},  // transmit empty cleared
    '{1'b1, KIND_TX_CLK,  8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},  // start bit
    '{1'b0, KIND_TX_CLK,  8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_DATA_WR, 8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0}},  // replaces bits mid-character
    '{1'b0, KIND_TX_CLK,  8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_RX_CLK,  8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_RX_CLK,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_CTRL_WR, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_CTRL_WR, 8'h01, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_CTRL_WR, 8'h02, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_CTRL_WR, 8'h7C, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b0, KIND_DATA_RD, 8'h00, 1'b0, '{8'h00, 1'b0, 1'b0}},
    '{1'b1, KIND_CTRL_WR, 8'h03, 1'b0, '{8'h00, 1'b1, 1'b0}},
    '{1'b1, KIND_STAT_RD, 8'h00, 1'b0, '{8'h02, 1'b1, 1'b0}}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  bus_word_t    stim_q[$];
  acia_result_t result_q[$];
  int           errors = 0;
  int           words_in = 0;
  bit           calm = 1'b0;
  bit           long_hold_active = 1'b0;
  int           quiet = 0;

  // Generator view of the current framing
  int unsigned  gen_div = 1;
  logic [2:0]   gen_fmt = '0;

  // Shadow of the interface state
  logic [7:0] ctl_word, stat_word, rx_hold, rx_sreg, tx_sreg;
  logic [3:0] rx_count, tx_count;
  logic       rx_par, tx_par;
  phase_t     rx_phase, tx_phase;
  logic       mreset_on, rx_on, tx_on, tx_level, irq_level;
  logic [1:0] div_code;
  logic [5:0] rx_pre, tx_pre;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  acia_serial_interface u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------- shadow model

  // Everything a master reset clears (control word, reset flag and divide survive)
  function automatic void clear_serial_state();
    stat_word = STS_TX_EMPTY;
    rx_hold   = '0;
    rx_sreg   = '0;
    tx_sreg   = '0;
    rx_count  = '0;
    tx_count  = '0;
    rx_par    = 1'b0;
    tx_par    = 1'b0;
    rx_phase  = PH_START;
    tx_phase  = PH_START;
    rx_on     = 1'b0;
    tx_on     = 1'b0;
    rx_pre    = '0;
    tx_pre    = '0;
    tx_level  = 1'b1;
    irq_level = 1'b0;
  endfunction

  function automatic par_t char_parity(input logic [2:0] fmt);
    case (fmt)
      3'd4, 3'd5:       return PAR_NONE;
      3'd1, 3'd3, 3'd7: return PAR_ODD;
      default:          return PAR_EVEN;
    endcase
  endfunction

  // True when this tick lands on a bit time; wraps the 6-bit count
  function automatic logic advance_prescale(inout logic [5:0] pre);
    logic [5:0]  nxt;
    int unsigned lim;
    lim = (div_code == DIV_16) ? 16 : (div_code == DIV_64) ? 64 : 1;
    nxt = pre + 6'd1;
    if (nxt >= lim || nxt == 6'd0) begin
      pre = '0;
      return 1'b1;
    end
    pre = nxt;
    return 1'b0;
  endfunction

  function automatic void rx_bit_time(input logic line);
    par_t par;
    par = char_parity(ctl_word[4:2]);
    case (rx_phase)
      PH_DATA: begin
        if (line) rx_sreg[7] = 1'b1;
        rx_par ^= line;
        if (rx_count <= 4'd1) begin
          rx_count = '0;
          if (!ctl_word[4]) rx_sreg = rx_sreg >> 1;  // 7-bit words end right-aligned
          rx_phase = (par == PAR_NONE) ? PH_STOP : PH_PARITY;
        end else begin
          rx_count = rx_count - 4'd1;
          rx_sreg  = rx_sreg >> 1;
        end
      end
      PH_PARITY: begin
        rx_par ^= line;
        if ((par == PAR_EVEN) ? rx_par : !rx_par) stat_word |= STS_PARITY_ERR;
        rx_par   = 1'b0;
        rx_phase = PH_STOP;
      end
      PH_STOP: rx_phase = PH_COMPLETE;  // stop level is not checked
      PH_COMPLETE: begin
        rx_hold    = rx_sreg;           // no overrun: a new word simply overwrites
        stat_word |= STS_RX_FULL;
        if (ctl_word[CTRL_RIE_BIT]) begin
          stat_word |= STS_IRQ;
          irq_level  = 1'b1;
        end
        rx_phase = PH_START;
      end
      default: begin
        if (!line) begin
          rx_sreg  = '0;
          rx_par   = 1'b0;
          rx_count = ctl_word[4] ? 4'd8 : 4'd7;
          rx_phase = PH_DATA;
        end
      end
    endcase
  endfunction

  function automatic void tx_bit_time();
    par_t par;
    par = char_parity(ctl_word[4:2]);
    case (tx_phase)
      PH_DATA: begin
        tx_level = tx_sreg[0];
        tx_par  ^= tx_sreg[0];
        tx_sreg  = tx_sreg >> 1;
        if (tx_count <= 4'd1) begin
          tx_count = '0;
          tx_phase = (par == PAR_NONE) ? PH_STOP : PH_PARITY;
        end else begin
          tx_count = tx_count - 4'd1;
        end
      end
      PH_PARITY: begin
        tx_level = (par == PAR_EVEN) ? tx_par : !tx_par;
        tx_par   = 1'b0;
        tx_phase = PH_STOP;
      end
      PH_STOP: begin
        tx_level = 1'b1;
        tx_phase = PH_COMPLETE;
      end
      PH_COMPLETE: begin
        stat_word |= STS_TX_EMPTY;
        tx_on      = 1'b0;
        tx_phase   = PH_START;
      end
      default: begin
        tx_level = 1'b0;
        tx_par   = 1'b0;
        tx_count = ctl_word[4] ? 4'd8 : 4'd7;
        tx_phase = PH_DATA;
      end
    endcase
  endfunction

  // Applies one bus word to the shadow state and returns the result word it gives
  function automatic acia_result_t apply_word(input logic [2:0] kind, input logic [7:0] wd,
                                              input logic rx);
    acia_result_t r;
    r.data = '0;
    case (kind)
      KIND_CTRL_WR: begin
        ctl_word = wd;
        if (wd[1:0] == DIV_MRESET) begin
          mreset_on = 1'b1;
          clear_serial_state();
        end else begin
          mreset_on = 1'b0;
          div_code  = wd[1:0];
          rx_on     = 1'b1;
          rx_pre    = '0;
        end
      end
      KIND_DATA_WR: begin
        if (!mreset_on) begin
          tx_sreg    = wd;
          stat_word &= ~STS_TX_EMPTY;
          tx_on      = 1'b1;
          tx_pre     = '0;
        end
      end
      KIND_STAT_RD: r.data = stat_word;
      KIND_DATA_RD: begin
        stat_word &= ~(STS_RX_FULL | STS_IRQ | STS_PARITY_ERR | STS_OVERRUN);
        irq_level  = 1'b0;
        r.data     = rx_hold;
      end
      KIND_RX_CLK: if (rx_on && advance_prescale(rx_pre)) rx_bit_time(rx);
      KIND_TX_CLK: if (tx_on && advance_prescale(tx_pre)) tx_bit_time();
      default: ;
    endcase
    r.tx  = tx_level;
    r.irq = irq_level;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void add_word(input logic [2:0] kind, input logic [7:0] wd,
                                   input logic rx);
    bus_word_t w;
    w       = '0;
    w.kind  = kind;
    w.wdata = wd;
    w.rx    = rx;
    stim_q.push_back(w);
  endfunction

  // Unrelated access dropped into the middle of a character
  function automatic void add_filler();
    case ($urandom_range(0, 3))
      0:       add_word(KIND_TX_CLK, 8'($urandom), 1'($urandom));
      1:       add_word(KIND_DATA_RD, 8'($urandom), 1'($urandom));
      default: add_word(KIND_STAT_RD, 8'($urandom), 1'($urandom));
    endcase
  endfunction

  function automatic void add_control(input logic [1:0] code);
    logic [7:0] cw;
    cw      = 8'($urandom);
    cw[1:0] = code;
    add_word(KIND_CTRL_WR, cw, 1'($urandom));
    if (code != DIV_MRESET) begin
      gen_fmt = cw[4:2];
      gen_div = (code == DIV_16) ? 16 : (code == DIV_64) ? 64 : 1;
    end
  endfunction

  // One line level held for a full bit time
  function automatic void add_rx_bit(input logic level);
    repeat (gen_div) begin
      add_word(KIND_RX_CLK, 8'($urandom), level);
      if ($urandom_range(0, 9) == 0) add_filler();
    end
  endfunction

  // Framed character on the receive line, mostly with good parity
  function automatic void add_rx_frame();
    logic [7:0] data;
    logic       has_par;
    logic       pbit;
    int         nb;
    data    = 8'($urandom);
    nb      = gen_fmt[2] ? 8 : 7;
    has_par = (gen_fmt[2:1] != 2'b10);
    pbit    = (^(gen_fmt[2] ? data : {1'b0, data[6:0]})) ^ gen_fmt[0];
    if ($urandom_range(0, 3) == 0) pbit = !pbit;
    repeat ($urandom_range(0, 2)) add_rx_bit(1'b1);
    add_rx_bit(1'b0);
    for (int i = 0; i < nb; i++) add_rx_bit(data[i]);
    if (has_par) add_rx_bit(pbit);
    add_rx_bit($urandom_range(0, 7) != 0);
    add_rx_bit(1'($urandom));
    // an unread word gets overwritten by the next one
    case ($urandom_range(0, 4))
      0, 1, 2: add_word(KIND_DATA_RD, 8'($urandom), 1'($urandom));
      3: begin
        add_word(KIND_STAT_RD, 8'($urandom), 1'($urandom));
        add_word(KIND_DATA_RD, 8'($urandom), 1'($urandom));
      end
      default: ;
    endcase
  endfunction

  // Data write followed by enough ticks to send it, now and then rewritten midway
  function automatic void add_tx_char();
    int ticks;
    ticks = ((gen_fmt[2] ? 8 : 7) + ((gen_fmt[2:1] != 2'b10) ? 1 : 0) + 3) * gen_div;
    add_word(KIND_DATA_WR, 8'($urandom), 1'($urandom));
    repeat (ticks) begin
      add_word(KIND_TX_CLK, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 9) == 0) add_filler();
      if ($urandom_range(0, 49) == 0) add_word(KIND_DATA_WR, 8'($urandom), 1'($urandom));
    end
    add_word(KIND_STAT_RD, 8'($urandom), 1'($urandom));
  endfunction

  // Control change; slow dividers and master reset get a short session, then divide 1
  function automatic void add_setup();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      add_control(DIV_1);
    end else if (r < 80) begin
      add_control(DIV_16);
      add_rx_frame();
      if ($urandom_range(0, 1) == 0) add_tx_char();
      add_control(DIV_1);
    end else if (r < 86) begin
      add_control(DIV_64);
      add_word(KIND_DATA_WR, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(100, 160)) begin
        add_word($urandom_range(0, 1) ? KIND_RX_CLK : KIND_TX_CLK, 8'($urandom),
                 1'($urandom));
      end
      add_control(DIV_1);
    end else begin
      add_control(DIV_MRESET);
      add_word(KIND_DATA_WR, 8'($urandom), 1'($urandom));
      add_word(KIND_STAT_RD, 8'($urandom), 1'($urandom));
      add_word(KIND_RX_CLK, 8'($urandom), 1'b0);
      add_control(DIV_1);
    end
  endfunction

  function automatic void add_noise();
    logic [2:0] kind;
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 19))
        0:       kind = KIND_SPARE_6;
        1:       kind = KIND_SPARE_7;
        default: kind = 3'($urandom_range(KIND_DATA_WR, KIND_TX_CLK));
      endcase
      add_word(kind, 8'($urandom), 1'($urandom));
    end
  endfunction

  // ---------------------------------------------------------------- sender

  initial begin : sender
    bus_word_t    w;
    acia_result_t got;
    int unsigned  r;

    clear_serial_state();
    ctl_word  = '0;
    mreset_on = 1'b0;
    div_code  = DIV_1;

    for (int i = 0; i < DIRECTED_COUNT; i++) stim_q.push_back(DIRECTED_ROWS[i]);
    add_setup();
    while (stim_q.size() < DIRECTED_COUNT + RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_setup();
      end else if (r < 50) begin
        add_rx_frame();
      end else if (r < 75) begin
        add_tx_char();
      end else if (r < 85) begin
        add_word(KIND_STAT_RD, 8'($urandom), 1'($urandom));
        add_word(KIND_DATA_RD, 8'($urandom), 1'($urandom));
      end else begin
        add_noise();
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    while (stim_q.size() != 0) begin
      w    = stim_q.pop_front();
      calm = (stim_q.size() < CALM_TAIL);
      if (words_in == PAUSE_AT) begin
        // stop offering until every outstanding result is back
        in_tvalid <= 1'b0;
        do @(posedge clk); while (result_q.size() != 0);
      end else if (!calm && !long_hold_active && $urandom_range(0, 7) == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata  <= {7'd0, w.rx, w.wdata};
      in_tuser  <= w.kind;
      do @(posedge clk); while (!in_tready);
      got = apply_word(w.kind, w.wdata, w.rx);
      result_q.push_back(w.typed ? w.want : got);
      words_in++;
    end
    in_tvalid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("acia_serial_interface verification clean");
    end else begin
      $display("acia_serial_interface verification failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Random stall bursts, one long hold-off to back up the input, none at the tail
  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!long_hold_active && words_in >= HOLD_AT && words_in < HOLD_AT + 10) begin
        long_hold_active = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
        long_hold_active = 1'b0;
        wait (words_in >= HOLD_AT + 10);
        @(posedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    acia_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (result_q.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: result word %h with nothing outstanding", $time, out_tdata);
        errors++;
      end else begin
        want = result_q.pop_front();
        if (out_tdata[7:0] !== want.data) begin
          if (errors < MAX_REPORTS)
            $display("%0t: read_data expected %h actual %h", $time, want.data, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[8] !== want.tx) begin
          if (errors < MAX_REPORTS)
            $display("%0t: tx_line expected %b actual %b", $time, want.tx, out_tdata[8]);
          errors++;
        end
        if (out_tdata[9] !== want.irq) begin
          if (errors < MAX_REPORTS)
            $display("%0t: irq_line expected %b actual %b", $time, want.irq, out_tdata[9]);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == WATCHDOG_LIMIT) begin
      $display("acia_serial_interface verification failed");
      $finish;
    end
  end

endmodule
